/* src/run_limited_sequence_counter_macros.svh */
// ----------------------------------------------------------------------------
// Run-limited sequence counter assertion macros
// Shorthand for clocked implication checks on the top level.
// ----------------------------------------------------------------------------
`ifndef RUN_LIMITED_SEQUENCE_COUNTER_MACROS_SVH
`define RUN_LIMITED_SEQUENCE_COUNTER_MACROS_SVH

// Same-cycle implication, checked on every clock outside of reset.
`define RLSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlsc same-cycle check failed");

// Next-cycle implication, checked on every clock outside of reset.
`define RLSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlsc next-cycle check failed");

`endif

/* src/rlsc_pkg.sv */
// ----------------------------------------------------------------------------
// Run-limited sequence counter package
// Shared widths, constants and controller-to-datapath signal groups.
// ----------------------------------------------------------------------------
package rlsc_pkg;

    // Default geometry.
    localparam int FACE_COUNT_DEF = 6;
    localparam int MAX_RUN_DEF    = 16;

    // Field widths.
    localparam int VAL_W      = 30;
    localparam int ROLL_W     = 16;
    localparam int LIM_W      = 5;
    localparam int REG_COUNT  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Arithmetic modulus and register reset value.
    localparam logic [VAL_W-1:0] MODULUS   = 30'd1000000007;
    localparam logic [LIM_W-1:0] LIM_RESET = 5'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic rd;
        logic term;
        logic upd;
        logic acc;
        logic len_end;
        logic load_result;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic last_len;
    } t_dp_sts;

endpackage

/* src/rlsc_datapath.sv */
// ----------------------------------------------------------------------------
// Run-limited sequence counter datapath
// Run limits, history memories and the modular arithmetic of the recurrence.
// ----------------------------------------------------------------------------
module rlsc_datapath #(
    parameter int  FACE_COUNT = rlsc_pkg::FACE_COUNT_DEF,
    parameter int  MAX_RUN    = rlsc_pkg::MAX_RUN_DEF,
    localparam int FACE_W     = $clog2(FACE_COUNT)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rlsc_pkg::t_dp_cmd               i_cmd,
    input  logic [FACE_W-1:0]               i_face,
    input  logic                            i_cfg_we,
    input  logic [rlsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rlsc_pkg::LIM_W-1:0]      i_cfg_data,
    input  logic [rlsc_pkg::ROLL_W-1:0]     i_roll_count,
    output rlsc_pkg::t_dp_sts               o_sts,
    output logic [rlsc_pkg::VAL_W-1:0]      o_result
);
    import rlsc_pkg::*;

    localparam int RING_DEPTH = MAX_RUN + 1;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int E_ADDR_W   = SLOT_W + FACE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [SLOT_W-1:0] RUN_MAX   = SLOT_W'(MAX_RUN);
    localparam logic [SLOT_W-1:0] RING_WRAP = SLOT_W'(RING_DEPTH);

    // (a - b) mod M for operands already below M.
    function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] d;
        d = a - b;
        if (a < b) begin
            d = d + MODULUS;
        end
        return d;
    endfunction

    // (a + b) mod M for operands already below M.
    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[VAL_W-1:0];
    endfunction

    logic [LIM_W-1:0]  r_limit [FACE_COUNT];
    logic [SLOT_W-1:0] lim_sat [FACE_COUNT];
    logic [SLOT_W-1:0] lim_cur;
    logic [SLOT_W-1:0] old_slot;
    logic [VAL_W-1:0]  w_val;

    logic [VAL_W-1:0]  mem_e [2**E_ADDR_W];
    logic [VAL_W-1:0]  mem_t [2**SLOT_W];

    logic [ROLL_W-1:0] r_n;
    logic [ROLL_W-1:0] r_len_m1;
    logic [SLOT_W-1:0] r_prev_slot;
    logic [SLOT_W-1:0] r_cur_slot;
    logic [VAL_W-1:0]  r_tp;
    logic [VAL_W-1:0]  r_total;
    logic [VAL_W-1:0]  r_e_rd;
    logic [VAL_W-1:0]  r_t_rd;
    logic [VAL_W-1:0]  r_term;
    logic [VAL_W-1:0]  r_w;
    logic [VAL_W-1:0]  r_result;
    logic              r_old_valid;
    logic              r_old_zero;
    logic              r_lim_zero;

    // Run limit registers; faces without a register keep a limit of one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FACE_COUNT; f++) begin
                r_limit[f] <= LIM_RESET;
            end
        end else if (i_cfg_we) begin
            for (int f = 0; f < FACE_COUNT; f++) begin
                if (f < REG_COUNT && int'(i_cfg_index) == f) begin
                    r_limit[f] <= i_cfg_data;
                end
            end
        end
    end

    // Limits saturated to MAX_RUN, one below the history ring depth.
    always_comb begin
        for (int f = 0; f < FACE_COUNT; f++) begin
            if (int'(r_limit[f]) > MAX_RUN) begin
                lim_sat[f] = RUN_MAX;
            end else begin
                lim_sat[f] = SLOT_W'(r_limit[f]);
            end
        end
    end

    // Slot of length i-1-L for the current face, wrapped around the ring.
    always_comb begin
        lim_cur = lim_sat[i_face];
        if (r_prev_slot >= lim_cur) begin
            old_slot = r_prev_slot - lim_cur;
        end else begin
            old_slot = r_prev_slot - lim_cur + RING_WRAP;
        end
    end

    // New ending count: zero for a zero limit, else the window telescopes to T[i-1] minus the dropped term.
    always_comb begin
        if (r_lim_zero) begin
            w_val = '0;
        end else if (r_old_valid) begin
            w_val = mod_sub(r_tp, r_term);
        end else begin
            w_val = r_tp;
        end
    end

    // History memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_e_rd <= mem_e[{old_slot, i_face}];
            r_t_rd <= mem_t[old_slot];
        end
        if (i_cmd.upd) begin
            mem_e[{r_cur_slot, i_face}] <= w_val;
        end
        if (i_cmd.len_end) begin
            mem_t[r_cur_slot] <= r_total;
        end
    end

    // Sequencing of lengths and the per-face arithmetic steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n         <= i_roll_count;
            r_len_m1    <= '0;
            r_prev_slot <= '0;
            r_cur_slot  <= SLOT_W'(1);
            r_tp        <= VAL_W'(1);
            r_total     <= '0;
        end
        if (i_cmd.rd) begin
            r_old_valid <= (r_len_m1 >= ROLL_W'(lim_cur));
            r_old_zero  <= (r_len_m1 == ROLL_W'(lim_cur));
            r_lim_zero  <= (lim_cur == '0);
        end
        if (i_cmd.term) begin
            // Length zero has T = 1 and E = 0 and is never stored.
            r_term <= r_old_zero ? VAL_W'(1) : mod_sub(r_t_rd, r_e_rd);
        end
        if (i_cmd.upd) begin
            r_w <= w_val;
        end
        if (i_cmd.acc) begin
            r_total <= mod_add(r_total, r_w);
        end
        if (i_cmd.len_end) begin
            r_tp        <= r_total;
            r_total     <= '0;
            r_prev_slot <= r_cur_slot;
            r_cur_slot  <= (r_cur_slot == LAST_SLOT) ? '0 : r_cur_slot + SLOT_W'(1);
            r_len_m1    <= r_len_m1 + ROLL_W'(1);
        end
        if (i_cmd.load_result) begin
            r_result <= r_tp;
        end
    end

    assign o_sts.n_zero   = (r_n == '0);
    assign o_sts.last_len = (r_len_m1 == r_n - ROLL_W'(1));
    assign o_result       = r_result;

endmodule

/* src/rlsc_ctrl.sv */
// ----------------------------------------------------------------------------
// Run-limited sequence counter controller
// Steps through lengths and faces and runs both stream handshakes.
// ----------------------------------------------------------------------------
module rlsc_ctrl #(
    parameter int  FACE_COUNT = rlsc_pkg::FACE_COUNT_DEF,
    localparam int FACE_W     = $clog2(FACE_COUNT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  rlsc_pkg::t_dp_sts i_sts,
    output rlsc_pkg::t_dp_cmd o_cmd,
    output logic [FACE_W-1:0] o_face
);
    import rlsc_pkg::*;

    localparam logic [FACE_W-1:0] LAST_FACE = FACE_W'(FACE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_TERM,
        ST_UPDATE,
        ST_ACCUM,
        ST_LEN_END,
        ST_FINISH
    } t_state;

    t_state            r_state;
    logic [FACE_W-1:0] r_face;
    logic              r_out_valid;

    // Command decode from the current state.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:    o_cmd.start       = i_s_tvalid;
            ST_READ:    o_cmd.rd          = 1'b1;
            ST_TERM:    o_cmd.term        = 1'b1;
            ST_UPDATE:  o_cmd.upd         = 1'b1;
            ST_ACCUM:   o_cmd.acc         = 1'b1;
            ST_LEN_END: o_cmd.len_end     = 1'b1;
            ST_FINISH:  o_cmd.load_result = !r_out_valid || i_m_tready;
            default:    o_cmd = '0;
        endcase
    end

    // State, face counter and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_face      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_face  <= '0;
                    r_state <= i_sts.n_zero ? ST_FINISH : ST_READ;
                end
                ST_READ:   r_state <= ST_TERM;
                ST_TERM:   r_state <= ST_UPDATE;
                ST_UPDATE: r_state <= ST_ACCUM;
                ST_ACCUM: begin
                    if (r_face == LAST_FACE) begin
                        r_face  <= '0;
                        r_state <= ST_LEN_END;
                    end else begin
                        r_face  <= r_face + FACE_W'(1);
                        r_state <= ST_READ;
                    end
                end
                ST_LEN_END: begin
                    r_state <= i_sts.last_len ? ST_FINISH : ST_READ;
                end
                ST_FINISH: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // The result register is loaded only once the previous one is taken.
            if (o_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_face     = r_face;

endmodule

/* src/run_limited_sequence_counter.sv */
// ----------------------------------------------------------------------------
// Run-limited sequence counter.
// Each roll length steps every face through the read, term, update and accumulate states
// over the modular arithmetic and history memories, then stores the total in the
// length-end state; one request at a time, taken only while idle.
// Reset clears control state and sets every run limit to one; no memory clear.
// ----------------------------------------------------------------------------
module run_limited_sequence_counter #(
    parameter int FACE_COUNT = rlsc_pkg::FACE_COUNT_DEF,
    parameter int MAX_RUN    = rlsc_pkg::MAX_RUN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rlsc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] roll_count
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rlsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [29:0] sequence_total
    // Run limit register writes.
    input  logic                              i_cfg_we,
    input  logic [rlsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlsc_pkg::LIM_W-1:0]        i_cfg_data
);
    import rlsc_pkg::*;

    localparam int FACE_W = $clog2(FACE_COUNT);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [FACE_W-1:0] face;
    logic [VAL_W-1:0]  result;

    // Sequencer.
    rlsc_ctrl #(
        .FACE_COUNT (FACE_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_face     (face)
    );

    // Arithmetic and history storage.
    rlsc_datapath #(
        .FACE_COUNT (FACE_COUNT),
        .MAX_RUN    (MAX_RUN)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_face       (face),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_roll_count (s_axis_tdata[ROLL_W-1:0]),
        .o_sts        (sts),
        .o_result     (result)
    );

    // Result packed into the low bits, zero filled to whole bytes.
    assign m_axis_tdata = {{(OUT_DATA_W - VAL_W){1'b0}}, result};

    `include "run_limited_sequence_counter_macros.svh"

    // A shown result is always fully reduced.
    `RLSC_ASSERT_SAME(a_result_reduced, m_axis_tvalid, result < MODULUS)
    // After a request is taken the block is busy.
    `RLSC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Loading the result register raises the output valid.
    `RLSC_ASSERT_NEXT(a_load_shows_result, cmd.load_result, m_axis_tvalid)
    // No result is loaded while a new request can be taken.
    `RLSC_ASSERT_SAME(a_load_not_idle, cmd.load_result, !s_axis_tready)

endmodule
